/* rtl/cna_pkg.sv */
// shared types, command codes and arithmetic helpers for the complex alu
package cna_pkg;

   // command codes
   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_SUB     = 3'd1;
   localparam logic [2:0] CMD_MUL     = 3'd2;
   localparam logic [2:0] CMD_DIV     = 3'd3;
   localparam logic [2:0] CMD_LESS    = 3'd4;
   localparam logic [2:0] CMD_GREATER = 3'd5;
   localparam logic [2:0] CMD_INC     = 3'd6;
   localparam logic [2:0] CMD_DEC     = 3'd7;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = 32;

   localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // result fields that travel alongside the divider
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic        cmp;
      logic        dz;
      logic        ovf;
   } side_type;

   // one restoring division lane
   typedef struct packed {
      logic [63:0] r;
      logic [31:0] nlo;
      logic [31:0] q;
      logic        neg;
      logic        hi;
   } lane_type;

   typedef struct packed {
      side_type          side;
      logic [63:0]       den;
      lane_type [1:0]    lane;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   // saturate an exact value to the signed 32 bit range
   function automatic sat_type sat32(logic signed [64:0] v);
      sat_type s;
      if (v[64:31] == '0 || v[64:31] == '1) begin
         s.val = v[31:0];
         s.ovf = 1'b0;
      end else begin
         s.val = v[64] ? SAT_NEG : SAT_POS;
         s.ovf = 1'b1;
      end
      return s;
   endfunction

   // one compare and subtract of the restoring divider
   function automatic lane_type div_step(lane_type l, logic [63:0] den);
      lane_type    n;
      logic [64:0] rs;
      logic [64:0] diff;
      n = l;
      rs = {l.r, l.nlo[31]};
      diff = rs - {1'b0, den};
      n.nlo = {l.nlo[30:0], 1'b0};
      if (!diff[64]) begin
         n.r = diff[63:0];
         n.q = {l.q[30:0], 1'b1};
      end else begin
         n.r = rs[63:0];
         n.q = {l.q[30:0], 1'b0};
      end
      return n;
   endfunction

   // apply sign and saturation to a finished quotient
   function automatic sat_type lane_finish(lane_type l);
      sat_type s;
      if (!l.neg) begin
         s.ovf = l.hi | l.q[31];
         s.val = s.ovf ? SAT_POS : l.q;
      end else begin
         s.ovf = l.hi | (l.q[31] & (|l.q[30:0]));
         s.val = s.ovf ? SAT_NEG : (32'd0 - l.q);
      end
      return s;
   endfunction

endpackage

/* rtl/cna_div.sv */
// pipelined restoring divider, two lanes sharing one divisor, one bit per stage
module cna_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  cna_pkg::side_type               in_side,
   input  logic [63:0]                     in_den,
   input  logic [63:0]                     in_mag_re,
   input  logic [63:0]                     in_mag_im,
   input  logic                            in_neg_re,
   input  logic                            in_neg_im,
   output logic                            out_valid,
   output cna_pkg::side_type               out_side,
   output cna_pkg::lane_type [1:0]         out_lane
);
   import cna_pkg::*;

   localparam int NUM_W = 64 + FRAC_BITS;

   logic [1:0][63:0]    mag;
   logic [1:0]          neg;
   logic [1:0][NUM_W-1:0] num;
   div_stage_type       st_in [0:DIV_STEPS];
   div_stage_type       st_ff [0:DIV_STEPS];
   logic                vld_ff [0:DIV_STEPS];

   assign mag[0] = in_mag_re;
   assign mag[1] = in_mag_im;
   assign neg[0] = in_neg_re;
   assign neg[1] = in_neg_im;

   // scaled numerator, first partial remainder and quotient range check
   always_comb begin
      st_in[0].side = in_side;
      st_in[0].den  = in_den;
      for (int k = 0; k < 2; k++) begin
         num[k] = NUM_W'(mag[k]) << FRAC_BITS;
         st_in[0].lane[k].r   = 64'(num[k][NUM_W-1:32]);
         st_in[0].lane[k].nlo = num[k][31:0];
         st_in[0].lane[k].q   = '0;
         st_in[0].lane[k].neg = neg[k];
         st_in[0].lane[k].hi  = (64'(num[k][NUM_W-1:32]) >= in_den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      st_ff[0] <= st_in[0];
   end

   // quotient bit stages
   for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
      always_comb begin
         st_in[g].side = st_ff[g-1].side;
         st_in[g].den  = st_ff[g-1].den;
         for (int k = 0; k < 2; k++) begin
            st_in[g].lane[k] = div_step(st_ff[g-1].lane[k], st_ff[g-1].den);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_ff[g-1];
         end
         st_ff[g] <= st_in[g];
      end
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_side  = st_ff[DIV_STEPS].side;
   assign out_lane  = st_ff[DIV_STEPS].lane;

endmodule

/* rtl/complex_number_alu.sv */
// order: operand, product, sum and set-up stages, divider, result register
// throughput: one command per cycle, busy stays low; the depth is set by the
// divider, which resolves one quotient bit per stage over 32 stages
// reset clears every valid bit of the pipeline; results in flight are dropped
// the receiver cannot stall, so each result strobe lasts exactly one cycle
module complex_number_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_compare_true,
   output logic               rsp_divide_by_zero,
   output logic               rsp_overflow
);
   import cna_pkg::*;

   localparam int LATENCY = 6 + DIV_STEPS;
   localparam logic signed [64:0] ONE = 65'sd1 <<< FRAC_BITS;

   // stage 1: operand registers
   logic               s1_vld_ff;
   logic [2:0]         s1_cmd_ff;
   logic signed [31:0] s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   // stage 2: products and simple results
   logic               s2_vld_ff;
   side_type           s2_side_in, s2_side_ff;
   logic signed [63:0] s2_prr_ff, s2_pii_ff, s2_pri_ff, s2_pir_ff;
   logic signed [63:0] s2_paa_r_ff, s2_paa_i_ff, s2_pbb_r_ff, s2_pbb_i_ff;
   sat_type            sa_re, sa_im;

   // stage 3: exact sums
   logic               s3_vld_ff;
   side_type           s3_side_ff;
   logic signed [64:0] s3_mre_ff, s3_mim_ff, s3_dre_ff, s3_dim_ff;
   logic [63:0]        s3_ma_ff, s3_mb_ff;

   // stage 4: multiply rounding, comparison, divider operands
   logic               s4_vld_ff;
   side_type           s4_side_in, s4_side_ff;
   logic [63:0]        s4_mag_re_in, s4_mag_im_in, s4_mag_re_ff, s4_mag_im_ff;
   logic [63:0]        s4_den_ff;
   logic               s4_neg_re_ff, s4_neg_im_ff;
   logic signed [64:0] sh_re, sh_im;
   sat_type            sm_re, sm_im;

   // divider outputs and result register
   logic               dv_vld;
   side_type           dv_side;
   lane_type [1:0]     dv_lane;
   sat_type            fq_re, fq_im;
   logic               rsp_strobe_ff;
   logic [31:0]        rsp_re_ff, rsp_im_ff;
   logic               rsp_cmp_ff, rsp_dz_ff, rsp_ovf_ff;

   assign busy = 1'b0;

   // input beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_cmd_ff <= req_command;
      s1_ar_ff  <= req_a_re;
      s1_ai_ff  <= req_a_im;
      s1_br_ff  <= req_b_re;
      s1_bi_ff  <= req_b_im;
   end

   // add, subtract, increment and decrement
   always_comb begin
      sa_re = '0;
      sa_im = '0;
      s2_side_in = '0;
      s2_side_in.cmd = s1_cmd_ff;
      case (s1_cmd_ff)
         CMD_ADD: begin
            sa_re = sat32(65'(s1_ar_ff) + 65'(s1_br_ff));
            sa_im = sat32(65'(s1_ai_ff) + 65'(s1_bi_ff));
         end
         CMD_SUB: begin
            sa_re = sat32(65'(s1_ar_ff) - 65'(s1_br_ff));
            sa_im = sat32(65'(s1_ai_ff) - 65'(s1_bi_ff));
         end
         CMD_INC: begin
            sa_re = sat32(65'(s1_ar_ff) + ONE);
            sa_im.val = s1_ai_ff;
         end
         CMD_DEC: begin
            sa_re = sat32(65'(s1_ar_ff) - ONE);
            sa_im.val = s1_ai_ff;
         end
         default: begin
            sa_re = '0;
            sa_im = '0;
         end
      endcase
      s2_side_in.res_re = sa_re.val;
      s2_side_in.res_im = sa_im.val;
      s2_side_in.ovf    = sa_re.ovf | sa_im.ovf;
   end

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_side_ff  <= s2_side_in;
      s2_prr_ff   <= s1_ar_ff * s1_br_ff;
      s2_pii_ff   <= s1_ai_ff * s1_bi_ff;
      s2_pri_ff   <= s1_ar_ff * s1_bi_ff;
      s2_pir_ff   <= s1_ai_ff * s1_br_ff;
      s2_paa_r_ff <= s1_ar_ff * s1_ar_ff;
      s2_paa_i_ff <= s1_ai_ff * s1_ai_ff;
      s2_pbb_r_ff <= s1_br_ff * s1_br_ff;
      s2_pbb_i_ff <= s1_bi_ff * s1_bi_ff;
   end

   // exact sums of products
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_side_ff <= s2_side_ff;
      s3_mre_ff  <= 65'(s2_prr_ff) - 65'(s2_pii_ff);
      s3_mim_ff  <= 65'(s2_pri_ff) + 65'(s2_pir_ff);
      s3_dre_ff  <= 65'(s2_prr_ff) + 65'(s2_pii_ff);
      s3_dim_ff  <= 65'(s2_pir_ff) - 65'(s2_pri_ff);
      s3_ma_ff   <= 64'(s2_paa_r_ff) + 64'(s2_paa_i_ff);
      s3_mb_ff   <= 64'(s2_pbb_r_ff) + 64'(s2_pbb_i_ff);
   end

   // multiply rounding, comparisons and divider set-up
   always_comb begin
      sh_re = s3_mre_ff >>> FRAC_BITS;
      sh_im = s3_mim_ff >>> FRAC_BITS;
      sm_re = sat32(sh_re);
      sm_im = sat32(sh_im);
      s4_mag_re_in = s3_dre_ff[64] ? 64'(-s3_dre_ff) : s3_dre_ff[63:0];
      s4_mag_im_in = s3_dim_ff[64] ? 64'(-s3_dim_ff) : s3_dim_ff[63:0];
      s4_side_in = s3_side_ff;
      case (s3_side_ff.cmd)
         CMD_MUL: begin
            s4_side_in.res_re = sm_re.val;
            s4_side_in.res_im = sm_im.val;
            s4_side_in.ovf    = sm_re.ovf | sm_im.ovf;
         end
         CMD_DIV: begin
            s4_side_in.dz = (s3_mb_ff == '0);
         end
         CMD_LESS: begin
            s4_side_in.cmp = (s3_ma_ff < s3_mb_ff);
         end
         CMD_GREATER: begin
            s4_side_in.cmp = (s3_ma_ff > s3_mb_ff);
         end
         default: begin
            s4_side_in = s3_side_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_side_ff   <= s4_side_in;
      s4_den_ff    <= s3_mb_ff;
      s4_mag_re_ff <= s4_mag_re_in;
      s4_mag_im_ff <= s4_mag_im_in;
      s4_neg_re_ff <= s3_dre_ff[64];
      s4_neg_im_ff <= s3_dim_ff[64];
   end

   cna_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_side   (s4_side_ff),
      .in_den    (s4_den_ff),
      .in_mag_re (s4_mag_re_ff),
      .in_mag_im (s4_mag_im_ff),
      .in_neg_re (s4_neg_re_ff),
      .in_neg_im (s4_neg_im_ff),
      .out_valid (dv_vld),
      .out_side  (dv_side),
      .out_lane  (dv_lane)
   );

   // quotient sign and saturation
   assign fq_re = lane_finish(dv_lane[0]);
   assign fq_im = lane_finish(dv_lane[1]);

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_vld;
      end
      rsp_cmp_ff <= dv_side.cmp;
      rsp_dz_ff  <= dv_side.dz;
      if (dv_side.cmd == CMD_DIV && !dv_side.dz) begin
         rsp_re_ff  <= fq_re.val;
         rsp_im_ff  <= fq_im.val;
         rsp_ovf_ff <= fq_re.ovf | fq_im.ovf;
      end else begin
         rsp_re_ff  <= dv_side.res_re;
         rsp_im_ff  <= dv_side.res_im;
         rsp_ovf_ff <= dv_side.ovf;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_res_re         = rsp_re_ff;
   assign rsp_res_im         = rsp_im_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_overflow       = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   // every accepted command comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result beat missing after pipeline latency");

   // zero divisor gives a clean zero result
   a_dz_zero: assert property (@(posedge clock)
      (rsp_strobe && rsp_divide_by_zero) |->
         (rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow))
      else $error("divide by zero result not cleared");

   // a comparison outcome carries no arithmetic flags
   a_cmp_flags: assert property (@(posedge clock)
      (rsp_strobe && rsp_compare_true) |->
         (!rsp_overflow && !rsp_divide_by_zero && rsp_res_re == '0))
      else $error("comparison beat carries arithmetic flags");

   // no beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result beat straight after reset");
`endif

endmodule

/* bench/complex_number_alu_tb.sv */
// self-checking testbench for the complex number alu
module complex_number_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cna_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 38;

   typedef struct {
      logic [2:0]         command;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } alu_operation_type;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               cmp;
      logic               dz;
      logic               ovf;
   } alu_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_command;
   logic signed [31:0] req_a_re;
   logic signed [31:0] req_a_im;
   logic signed [31:0] req_b_re;
   logic signed [31:0] req_b_im;
   logic               rsp_strobe;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic               rsp_compare_true;
   logic               rsp_divide_by_zero;
   logic               rsp_overflow;

   alu_result_type results_due[$];
   bit             failed;
   int             burst_left;

   complex_number_alu #(.FRAC_BITS(FRAC)) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_a_re           (req_a_re),
      .req_a_im           (req_a_im),
      .req_b_re           (req_b_re),
      .req_b_im           (req_b_im),
      .rsp_strobe         (rsp_strobe),
      .rsp_res_re         (rsp_res_re),
      .rsp_res_im         (rsp_res_im),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflow       (rsp_overflow)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // saturate an exact value into the q16.16 range
   function automatic logic signed [31:0] clamp_q(input logic signed [97:0] v,
                                                  inout logic ovf);
      if (v > 98'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7fff_ffff;
      end
      if (v < -98'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // quotient part: numerator * 2^frac / den, truncated toward zero, saturated
   function automatic logic signed [31:0] div_quotient(input logic signed [97:0] num,
                                                       input logic [97:0] den,
                                                       inout logic ovf);
      logic        neg;
      logic [97:0] mag;
      logic [97:0] q;
      logic [97:0] limit;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag << FRAC) / den;
      limit = neg ? 98'd2147483648 : 98'd2147483647;
      if (q > limit) begin
         ovf = 1'b1;
         q = limit;
      end
      if (neg) q = -q;
      return q[31:0];
   endfunction

   // expected result of one command
   function automatic alu_result_type complex_alu_predict(input alu_operation_type op);
      alu_result_type     r;
      logic signed [97:0] ar, ai, br, bi, one, ma, mb, s;
      ar = 98'(op.a_re);
      ai = 98'(op.a_im);
      br = 98'(op.b_re);
      bi = 98'(op.b_im);
      one = 98'sd1 <<< FRAC;
      r = '{default: '0};
      ma = ar * ar + ai * ai;
      mb = br * br + bi * bi;
      case (op.command)
         CMD_ADD: begin
            r.re = clamp_q(ar + br, r.ovf);
            r.im = clamp_q(ai + bi, r.ovf);
         end
         CMD_SUB: begin
            r.re = clamp_q(ar - br, r.ovf);
            r.im = clamp_q(ai - bi, r.ovf);
         end
         CMD_MUL: begin
            s = ar * br - ai * bi;
            r.re = clamp_q(s >>> FRAC, r.ovf);
            s = ar * bi + ai * br;
            r.im = clamp_q(s >>> FRAC, r.ovf);
         end
         CMD_DIV: begin
            if (mb == 0) begin
               r.dz = 1'b1;
            end else begin
               r.re = div_quotient(ar * br + ai * bi, mb, r.ovf);
               r.im = div_quotient(ai * br - ar * bi, mb, r.ovf);
            end
         end
         CMD_LESS:    r.cmp = ma < mb;
         CMD_GREATER: r.cmp = ma > mb;
         CMD_INC: begin
            r.re = clamp_q(ar + one, r.ovf);
            r.im = op.a_im;
         end
         default: begin
            r.re = clamp_q(ar - one, r.ovf);
            r.im = op.a_im;
         end
      endcase
      return r;
   endfunction

   // send one beat, with bursts and random gaps
   task automatic send_op(input alu_operation_type op);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start       <= 1'b1;
      req_command <= op.command;
      req_a_re    <= op.a_re;
      req_a_im    <= op.a_im;
      req_b_re    <= op.b_re;
      req_b_im    <= op.b_im;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      results_due.push_back(complex_alu_predict(op));
   endtask

   task automatic send(input logic [2:0] c, input logic signed [31:0] a_re,
                       input logic signed [31:0] a_im, input logic signed [31:0] b_re,
                       input logic signed [31:0] b_im);
      alu_operation_type op;
      op = '{c, a_re, a_im, b_re, b_im};
      send_op(op);
   endtask

   // operand with a mix of shapes: full range, small, extremes, whole units
   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2:    return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0000_0000;
               3: return 32'sh8000_0001;
               default: return 32'sh7fff_0000;
            endcase
         end
         default: return ($signed($urandom_range(0, 64)) - 32'sd32) <<< FRAC;
      endcase
   endfunction

   localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;

   task automatic test_add_sub();
      send(CMD_ADD, MAXV, MINV, ONE, -ONE);
      send(CMD_ADD, MINV, MAXV, MINV, MAXV);
      send(CMD_SUB, MINV, MAXV, ONE, -ONE);
      send(CMD_SUB, 32'sd5, -32'sd7, 32'sd3, 32'sd9);
   endtask

   task automatic test_mul();
      send(CMD_MUL, MINV, MINV, MINV, MINV);
      send(CMD_MUL, MINV, MAXV, MINV, MINV);
      send(CMD_MUL, ONE, ONE, -ONE, ONE);
      send(CMD_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
   endtask

   task automatic test_div();
      send(CMD_DIV, ONE, ONE, 32'sd0, 32'sd0);
      send(CMD_DIV, MAXV, MINV, 32'sd1, 32'sd0);
      send(CMD_DIV, MINV, MINV, MINV, MINV);
      send(CMD_DIV, -ONE, 32'sd3, 32'sd2 * ONE, -ONE);
      send(CMD_DIV, 32'sd1, -32'sd1, MAXV, MAXV);
   endtask

   task automatic test_compare();
      // ties, then either order
      send(CMD_LESS, ONE, -ONE, -ONE, ONE);
      send(CMD_GREATER, ONE, -ONE, -ONE, ONE);
      send(CMD_LESS, MINV, MINV, MAXV, MAXV);
      send(CMD_GREATER, MINV, MINV, MAXV, MAXV);
      send(CMD_LESS, 32'sd0, 32'sd0, 32'sd0, 32'sd1);
   endtask

   task automatic test_inc_dec();
      send(CMD_INC, MAXV, MINV, MAXV, MINV);
      send(CMD_INC, -ONE, 32'sd7, 32'sd0, 32'sd0);
      send(CMD_DEC, MINV, MAXV, MINV, MAXV);
      send(CMD_DEC, ONE, -32'sd1, 32'sd0, 32'sd0);
   endtask

   task automatic test_random(input int count);
      alu_operation_type op;
      repeat (count) begin
         op.command = 3'($urandom_range(0, 7));
         op.a_re = rand_operand();
         op.a_im = rand_operand();
         op.b_re = rand_operand();
         op.b_im = rand_operand();
         // divide by zero now and then
         if (op.command == CMD_DIV && $urandom_range(0, 9) == 0) begin
            op.b_re = '0;
            op.b_im = '0;
         end
         send_op(op);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            $error("unexpected result beat");
            failed = 1'b1;
         end else begin
            e = results_due.pop_front();
            if (rsp_res_re !== e.re) begin
               $error("res_re expected %h got %h", e.re, rsp_res_re);
               failed = 1'b1;
            end
            if (rsp_res_im !== e.im) begin
               $error("res_im expected %h got %h", e.im, rsp_res_im);
               failed = 1'b1;
            end
            if (rsp_compare_true !== e.cmp) begin
               $error("compare_true expected %b got %b", e.cmp, rsp_compare_true);
               failed = 1'b1;
            end
            if (rsp_divide_by_zero !== e.dz) begin
               $error("divide_by_zero expected %b got %b", e.dz, rsp_divide_by_zero);
               failed = 1'b1;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow expected %b got %b", e.ovf, rsp_overflow);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("complex_number_alu_tb failed");
      $finish;
   end

   // test sequence
   initial begin
      failed = 1'b0;
      burst_left = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_ADD;
      req_a_re <= '0;
      req_a_im <= '0;
      req_b_re <= '0;
      req_b_im <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_add_sub();
      test_mul();
      test_div();
      test_compare();
      test_inc_dec();
      test_random(800);
      start <= 1'b0;
      wait (results_due.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (!failed && results_due.size() == 0) begin
         $display("complex_number_alu_tb passed");
      end else begin
         $display("complex_number_alu_tb failed");
      end
      $finish;
   end
endmodule
